/* hdl/ravg_pkg.sv */
`timescale 1ns / 1ps

package ravg_pkg;

  // default sizes, handed to the top level parameters
  localparam int DEF_MAX_SENSORS = 32;
  localparam int DEF_AVG_LEN     = 5;

  // entries of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic        [15:0] id_t;
  typedef logic signed [15:0] temp_t;
  typedef logic        [31:0] time_t;

  // result status codes, also used as command kinds in the queue
  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_SAMPLE  = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    MODE_MAP     = 1'b0,
    MODE_MEASURE = 1'b1
  } mode_t;

  typedef enum logic {
    CFG_MAX_TEMP = 1'b0,
    CFG_MIN_TEMP = 1'b1
  } cfg_index_t;

  localparam temp_t MAX_TEMP_RESET = 16'sd7680;
  localparam temp_t MIN_TEMP_RESET = 16'sd2560;

  // classified work item handed from front to back
  typedef struct packed {
    status_t kind;
    temp_t   temperature;
    time_t   timestamp;
  } cmd_t;

  // alarm thresholds
  typedef struct packed {
    temp_t max_temp;
    temp_t min_temp;
  } thresh_t;

endpackage

/* hdl/ravg_in_if.sv */
`timescale 1ns / 1ps

interface ravg_in_if;
  import ravg_pkg::*;

  logic  valid;
  logic  ready;
  logic  mode;
  id_t   probe_id;
  id_t   room_id;
  temp_t temperature;
  time_t timestamp;

  modport source (
    output valid, mode, probe_id, room_id, temperature, timestamp,
    input  ready
  );

  modport sink (
    input  valid, mode, probe_id, room_id, temperature, timestamp,
    output ready
  );
endinterface

/* hdl/ravg_out_if.sv */
`timescale 1ns / 1ps

interface ravg_out_if;
  import ravg_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  id_t     room;
  temp_t   average;
  logic    too_hot;
  logic    too_cold;
  time_t   last_time;

  modport source (
    output valid, status, room, average, too_hot, too_cold, last_time,
    input  ready
  );

  modport sink (
    input  valid, status, room, average, too_hot, too_cold, last_time,
    output ready
  );
endinterface

/* hdl/ravg_ram.sv */
`timescale 1ns / 1ps

module ravg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ravg_queue.sv */
`timescale 1ns / 1ps

module ravg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_level: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue level did not follow a lone write");

endmodule

/* hdl/ravg_front.sv */
`timescale 1ns / 1ps

module ravg_front #(
  parameter int MAX_SENSORS = ravg_pkg::DEF_MAX_SENSORS
) (
  input  logic                  clk,
  input  logic                  rst,
  ravg_in_if.sink               item,
  output ravg_pkg::cmd_t        cmd,
  output logic [(MAX_SENSORS > 1 ? $clog2(MAX_SENSORS) : 1)-1:0] cmd_hit,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output logic                  room_we,
  output logic [(MAX_SENSORS > 1 ? $clog2(MAX_SENSORS) : 1)-1:0] room_waddr,
  output ravg_pkg::id_t         room_wdata
);
  import ravg_pkg::*;

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CNT_W = $clog2(MAX_SENSORS + 1);

  typedef enum logic [3:0] {
    F_IDLE     = 4'b0001,
    F_CLASSIFY = 4'b0010,
    F_SCAN     = 4'b0100,
    F_PUSH     = 4'b1000
  } f_state_t;

  f_state_t   f_state;
  f_state_t   f_state_next;
  logic       in_mode;
  id_t        in_probe_id;
  id_t        in_room_id;
  temp_t      in_temperature;
  time_t      in_timestamp;
  logic [CNT_W-1:0] entry_count;
  logic [IDX_W-1:0] scan_idx;
  status_t    kind;
  logic [IDX_W-1:0] hit;
  logic       id_re;
  logic [IDX_W-1:0] id_raddr;
  id_t        id_rdata;
  logic       table_full;
  logic       scan_last;
  logic       id_match;

  assign item.ready = (f_state == F_IDLE);
  assign table_full = (entry_count == CNT_W'(MAX_SENSORS));
  assign scan_last  = ((CNT_W'(scan_idx) + 1'b1) == entry_count);
  assign id_match   = (id_rdata == in_probe_id);

  // sensor id table, searched one entry a cycle
  ravg_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SENSORS)
  ) u_id_ram (
    .clk   (clk),
    .we    (room_we),
    .waddr (room_waddr),
    .wdata (in_probe_id),
    .re    (id_re),
    .raddr (id_raddr),
    .rdata (id_rdata)
  );

  // map entry write, shared by the id and room tables
  assign room_we    = (f_state == F_CLASSIFY) && (mode_t'(in_mode) == MODE_MAP) && !table_full;
  assign room_waddr = entry_count[IDX_W-1:0];
  assign room_wdata = in_room_id;

  // id table read: first entry on classify, next entry while scanning
  always_comb begin
    id_re    = 1'b0;
    id_raddr = '0;
    if (f_state == F_CLASSIFY) begin
      id_re = (mode_t'(in_mode) == MODE_MEASURE) && (entry_count != '0);
    end else if (f_state == F_SCAN) begin
      id_re    = !id_match && !scan_last;
      id_raddr = scan_idx + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    f_state_next = f_state;
    unique case (f_state)
      F_IDLE: begin
        if (item.valid) begin
          f_state_next = F_CLASSIFY;
        end
      end
      F_CLASSIFY: begin
        if ((mode_t'(in_mode) == MODE_MEASURE) && (entry_count != '0)) begin
          f_state_next = F_SCAN;
        end else begin
          f_state_next = F_PUSH;
        end
      end
      F_SCAN: begin
        if (id_match || scan_last) begin
          f_state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (cmd_ready) begin
          f_state_next = F_IDLE;
        end
      end
      default: f_state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_state     <= F_IDLE;
      entry_count <= '0;
    end else begin
      f_state <= f_state_next;
      if (room_we) begin
        entry_count <= entry_count + 1'b1;
      end
    end
  end

  // captured transaction, scan index and the command being built
  always_ff @(posedge clk) begin
    if (f_state == F_IDLE && item.valid) begin
      in_mode        <= item.mode;
      in_probe_id    <= item.probe_id;
      in_room_id     <= item.room_id;
      in_temperature <= item.temperature;
      in_timestamp   <= item.timestamp;
    end
    unique case (f_state)
      F_CLASSIFY: begin
        scan_idx <= '0;
        hit      <= '0;
        if (mode_t'(in_mode) == MODE_MAP) begin
          kind <= table_full ? ST_FULL : ST_STORED;
        end else begin
          kind <= ST_UNKNOWN;
        end
      end
      F_SCAN: begin
        if (id_match) begin
          kind <= ST_SAMPLE;
          hit  <= scan_idx;
        end else if (!scan_last) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_valid       = (f_state == F_PUSH);
  assign cmd.kind        = kind;
  assign cmd.temperature = in_temperature;
  assign cmd.timestamp   = in_timestamp;
  assign cmd_hit         = hit;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(MAX_SENSORS))
    else $error("entry count beyond table size");
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (f_state == F_SCAN) |-> (CNT_W'(scan_idx) < entry_count))
    else $error("scan beyond filled entries");
  a_push_done: assert property (@(posedge clk) disable iff (rst)
    (f_state == F_PUSH && cmd_ready) |=> (f_state == F_IDLE))
    else $error("front did not return to idle after handing over");

endmodule

/* hdl/ravg_back.sv */
`timescale 1ns / 1ps

module ravg_back #(
  parameter int MAX_SENSORS = ravg_pkg::DEF_MAX_SENSORS,
  parameter int AVG_LEN     = ravg_pkg::DEF_AVG_LEN
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ravg_pkg::thresh_t    thresh,
  input  ravg_pkg::cmd_t       head,
  input  logic [(MAX_SENSORS > 1 ? $clog2(MAX_SENSORS) : 1)-1:0] head_hit,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 room_re,
  output logic [(MAX_SENSORS > 1 ? $clog2(MAX_SENSORS) : 1)-1:0] room_raddr,
  input  ravg_pkg::id_t        room_rdata,
  ravg_out_if.source           result
);
  import ravg_pkg::*;

  localparam int IDX_W  = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int SUM_W  = 16 + $clog2(AVG_LEN);
  localparam int FILL_W = $clog2(AVG_LEN + 1);
  localparam int PTR_W  = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int META_W = SUM_W + FILL_W + PTR_W;
  localparam int SDEPTH = MAX_SENSORS * AVG_LEN;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  // exact division by AVG_LEN: multiply by a rounded-up reciprocal, shift by K
  localparam int K      = SUM_W + $clog2(AVG_LEN);
  localparam longint unsigned RECIP = ((64'd1 << K) + AVG_LEN - 1) / AVG_LEN;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_META = 5'b00010,
    B_SAMP = 5'b00100,
    B_MUL  = 5'b01000,
    B_DONE = 5'b10000
  } b_state_t;

  b_state_t b_state;
  b_state_t b_state_next;

  logic [MAX_SENSORS-1:0] row_valid;
  logic                   meta_re;
  logic                   meta_we;
  logic [META_W-1:0]      meta_rdata;
  logic [META_W-1:0]      meta_wdata;
  logic                   samp_re;
  logic                   samp_we;
  logic [SAW-1:0]         samp_raddr;
  logic [15:0]            samp_rdata;

  logic signed [SUM_W-1:0] sum_rd;
  logic [FILL_W-1:0]       fill_rd;
  logic [PTR_W-1:0]        ptr_rd;
  logic signed [SUM_W-1:0] sum_q;
  logic [FILL_W-1:0]       fill_q;
  logic [PTR_W-1:0]        ptr_q;
  logic [SAW-1:0]          samp_addr_q;
  logic                    was_full;
  logic signed [SUM_W-1:0] oldest;
  logic signed [SUM_W-1:0] new_sum;
  logic [FILL_W-1:0]       fill_next;
  logic [PTR_W-1:0]        ptr_next;
  logic [SUM_W-1:0]        mag_q;
  logic                    neg_q;
  logic                    was_full_q;
  logic [PROD_W-1:0]       prod_q;
  logic [15:0]             quot;
  temp_t                   avg;
  logic                    can_load;
  logic                    head_sample;

  logic    out_valid;
  status_t out_status;
  id_t     out_room;
  temp_t   out_average;
  logic    out_hot;
  logic    out_cold;
  time_t   out_time;

  assign head_sample = !q_empty && (head.kind == ST_SAMPLE);
  assign can_load    = !out_valid || result.ready;

  // per-sensor sum, fill level and oldest-slot pointer
  ravg_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_SENSORS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (head_hit),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (head_hit),
    .rdata (meta_rdata)
  );

  // sample windows, kept as one ring per sensor
  ravg_ram #(
    .WIDTH (16),
    .DEPTH (SDEPTH)
  ) u_samp_ram (
    .clk   (clk),
    .we    (samp_we),
    .waddr (samp_addr_q),
    .wdata (head.temperature),
    .re    (samp_re),
    .raddr (samp_raddr),
    .rdata (samp_rdata)
  );

  assign meta_re    = (b_state == B_IDLE) && head_sample;
  assign room_re    = meta_re;
  assign room_raddr = head_hit;

  // a row never touched since reset reads as an empty window
  assign sum_rd  = row_valid[head_hit] ? $signed(meta_rdata[META_W-1 -: SUM_W]) : '0;
  assign fill_rd = row_valid[head_hit] ? meta_rdata[PTR_W +: FILL_W] : '0;
  assign ptr_rd  = row_valid[head_hit] ? meta_rdata[PTR_W-1:0] : '0;

  assign samp_re    = (b_state == B_META);
  assign samp_raddr = SAW'(head_hit) * SAW'(AVG_LEN) + SAW'(ptr_rd);

  // window update: drop the oldest sample once the ring is full
  assign was_full   = (fill_q == FILL_W'(AVG_LEN));
  assign oldest     = was_full ? SUM_W'($signed(samp_rdata)) : '0;
  assign new_sum    = sum_q - oldest + SUM_W'(head.temperature);
  assign fill_next  = was_full ? fill_q : fill_q + 1'b1;
  assign ptr_next   = (ptr_q == PTR_W'(AVG_LEN - 1)) ? '0 : ptr_q + 1'b1;
  assign meta_we    = (b_state == B_SAMP);
  assign samp_we    = meta_we;
  assign meta_wdata = {new_sum, fill_next, ptr_next};

  // quotient magnitude and sign restore, truncation toward zero
  assign quot = prod_q[K +: 16];
  assign avg  = neg_q ? temp_t'(-quot) : temp_t'(quot);

  // sequencer
  always_comb begin
    b_state_next = b_state;
    unique case (b_state)
      B_IDLE:  if (head_sample) b_state_next = B_META;
      B_META:  b_state_next = B_SAMP;
      B_SAMP:  b_state_next = B_MUL;
      B_MUL:   b_state_next = B_DONE;
      B_DONE:  if (can_load) b_state_next = B_IDLE;
      default: b_state_next = B_IDLE;
    endcase
  end

  assign q_pop = can_load && (((b_state == B_IDLE) && !q_empty && !head_sample)
                              || (b_state == B_DONE));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_state   <= B_IDLE;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      b_state <= b_state_next;
      if (meta_we) begin
        row_valid[head_hit] <= 1'b1;
      end
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (b_state == B_META) begin
      sum_q       <= sum_rd;
      fill_q      <= fill_rd;
      ptr_q       <= ptr_rd;
      samp_addr_q <= samp_raddr;
    end
    if (b_state == B_SAMP) begin
      neg_q      <= new_sum[SUM_W-1];
      mag_q      <= new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
      was_full_q <= was_full;
    end
    if (b_state == B_MUL) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP_W'(RECIP));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (b_state == B_DONE) begin
        out_status  <= ST_SAMPLE;
        out_room    <= room_rdata;
        out_average <= avg;
        out_hot     <= was_full_q && (avg > thresh.max_temp);
        out_cold    <= was_full_q && (avg < thresh.min_temp);
        out_time    <= head.timestamp;
      end else begin
        out_status  <= head.kind;
        out_room    <= '0;
        out_average <= '0;
        out_hot     <= 1'b0;
        out_cold    <= 1'b0;
        out_time    <= '0;
      end
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.room      = out_room;
  assign result.average   = out_average;
  assign result.too_hot   = out_hot;
  assign result.too_cold  = out_cold;
  assign result.last_time = out_time;

  a_busy_on_sample: assert property (@(posedge clk) disable iff (rst)
    (b_state != B_IDLE) |-> (!q_empty && head.kind == ST_SAMPLE))
    else $error("window update running without a sample at the queue head");
  a_pop_slot_free: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!result.valid || result.ready))
    else $error("result overwritten before it was taken");
  a_plain_status_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_SAMPLE) |->
      (result.average == '0 && !result.too_hot && !result.too_cold &&
       result.room == '0 && result.last_time == '0))
    else $error("non-sample result carries data");

endmodule

/* hdl/sensor_running_average_monitor.sv */
`timescale 1ns / 1ps

// channel  dir  handshake    payload
// item     in   valid/ready  mode, probe_id, room_id, temperature, timestamp
// result   out  valid/ready  status, room, average, too_hot, too_cold, last_time
// cfg      in   cfg_we       cfg_index, cfg_data (0 max_temp, 1 min_temp)
//
// map entry: the front captures, classifies and hands over; the back passes the status on.
// measurement: the front captures, classifies, then searches the id table one entry a
// cycle until it finds the matching entry or passes the last one (unknown sensor);
// the back then does the sum/sample read-modify-write and the divide.
// reset is synchronous; per-sensor valid bits stand for the zeroed windows, no sweep.
// a two-entry queue parts front and back; a held result stalls the back, and the
// front too once the queue is full.

module sensor_running_average_monitor #(
  parameter int MAX_SENSORS = ravg_pkg::DEF_MAX_SENSORS,
  parameter int AVG_LEN     = ravg_pkg::DEF_AVG_LEN
) (
  input  logic        clk,
  input  logic        rst,
  ravg_in_if.sink     item,
  ravg_out_if.source  result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ravg_pkg::*;

  localparam int IDX_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
  localparam int CMD_W = $bits(cmd_t);
  localparam int QW    = IDX_W + CMD_W;

  thresh_t          thresh;
  cmd_t             f_cmd;
  logic [IDX_W-1:0] f_hit;
  logic             f_valid;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  logic [QW-1:0]    q_rdata;
  cmd_t             head;
  logic [IDX_W-1:0] head_hit;
  logic             room_we;
  logic [IDX_W-1:0] room_waddr;
  id_t              room_wdata;
  logic             room_re;
  logic [IDX_W-1:0] room_raddr;
  id_t              room_rdata;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thresh.max_temp <= MAX_TEMP_RESET;
      thresh.min_temp <= MIN_TEMP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MAX_TEMP: thresh.max_temp <= cfg_data;
        CFG_MIN_TEMP: thresh.min_temp <= cfg_data;
      endcase
    end
  end

  ravg_front #(
    .MAX_SENSORS (MAX_SENSORS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cmd        (f_cmd),
    .cmd_hit    (f_hit),
    .cmd_valid  (f_valid),
    .cmd_ready  (!q_full),
    .room_we    (room_we),
    .room_waddr (room_waddr),
    .room_wdata (room_wdata)
  );

  ravg_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (f_valid && !q_full),
    .wdata ({f_hit, f_cmd}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign head     = cmd_t'(q_rdata[CMD_W-1:0]);
  assign head_hit = q_rdata[QW-1 -: IDX_W];

  // room table: written by the front on append, read by the back on a hit
  ravg_ram #(
    .WIDTH (16),
    .DEPTH (MAX_SENSORS)
  ) u_room_ram (
    .clk   (clk),
    .we    (room_we),
    .waddr (room_waddr),
    .wdata (room_wdata),
    .re    (room_re),
    .raddr (room_raddr),
    .rdata (room_rdata)
  );

  ravg_back #(
    .MAX_SENSORS (MAX_SENSORS),
    .AVG_LEN     (AVG_LEN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .thresh     (thresh),
    .head       (head),
    .head_hit   (head_hit),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .room_re    (room_re),
    .room_raddr (room_raddr),
    .room_rdata (room_rdata),
    .result     (result)
  );

endmodule
